>>> hdl/skf_pkg.sv
// Shared types, constants and helpers for the scalar angle Kalman filter.
// No dependencies; used by the top level, the checker and the bench.
package skf_pkg;

    // Field widths
    localparam int ANGLE_W  = 32;   // signed Q16.16 angle and rate
    localparam int VAR_W    = 32;   // unsigned Q8.24 variance
    localparam int PERIOD_W = 16;   // unsigned Q0.16 sample period
    localparam int GAIN_W   = 17;   // unsigned Q1.16 gain, 0..65536
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Derived widths of the serial units
    localparam int DEN_W   = VAR_W + 1;           // P + R
    localparam int ERR_W   = ANGLE_W + 1;         // measured minus predicted
    localparam int SUM_W   = ANGLE_W + 4;         // headroom for saturating sums

    // Constants
    localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(66);
    localparam logic [VAR_W-1:0] QNOISE_RST = '0;
    localparam logic [VAR_W-1:0] RNOISE_RST = VAR_W'(45996);
    localparam logic [VAR_W-1:0] VAR_RST = VAR_W'(878450);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE  = CFG_IDX_W'(3);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_PHASE1,
        S_PRED,
        S_ERR,
        S_PHASE2,
        S_FINISH
    } t_state;

    // Clamp a wide signed sum to the signed 32-bit range
    function automatic logic signed [ANGLE_W-1:0] sat_s32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(2147483647);
        lo = -SUM_W'(2147483647) - SUM_W'(1);
        if (v > hi) begin
            sat_s32 = ANGLE_W'(32'h7FFF_FFFF);
        end else if (v < lo) begin
            sat_s32 = ANGLE_W'(32'h8000_0000);
        end else begin
            sat_s32 = v[ANGLE_W-1:0];
        end
    endfunction

endpackage

>>> hdl/scalar_angle_kalman_filter.sv
// Top level of the scalar angle Kalman filter: sequencer, state and output register.
// Depends on skf_pkg, skf_serial_mul and skf_serial_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per IMU sample:
//   measured angle and gyro rate, both signed Q16.16. Output channel
//   (o_out_valid / i_out_ready) returns one beat per input: filtered angle,
//   gain and updated variance. Configuration writes (i_cfg_valid, always
//   ready) set sample period, process noise, measurement noise and the
//   initial variance; the last also reloads the variance state. Write
//   configuration only while the filter is idle.
//   Each item runs the bit-serial gain divider (the rate product runs beside
//   it), then the two bit-serial gain products, which run side by side.
//   One item is in work at a time; the output register holds a finished
//   result while the next item is taken and worked on. If the receiver
//   stalls, the next result waits in the last step until the output
//   register frees up.
//   Reset returns the configuration to its defaults, clears the angle and
//   loads the variance with the default initial variance.
module scalar_angle_kalman_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input beats
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [skf_pkg::ANGLE_W-1:0]     i_measured_angle,
    input  logic signed [skf_pkg::ANGLE_W-1:0]     i_angular_rate,
    // result beats
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [skf_pkg::ANGLE_W-1:0]     o_angle_estimate,
    output logic [skf_pkg::GAIN_W-1:0]             o_gain_used,
    output logic [skf_pkg::VAR_W-1:0]              o_variance_now,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [skf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int ANGLE_W  = skf_pkg::ANGLE_W;
    localparam int VAR_W    = skf_pkg::VAR_W;
    localparam int PERIOD_W = skf_pkg::PERIOD_W;
    localparam int GAIN_W   = skf_pkg::GAIN_W;
    localparam int DEN_W    = skf_pkg::DEN_W;
    localparam int ERR_W    = skf_pkg::ERR_W;
    localparam int SUM_W    = skf_pkg::SUM_W;
    localparam int DP_W     = ANGLE_W + PERIOD_W;   // rate * period
    localparam int EP_W     = ERR_W + GAIN_W;       // err * gain, P * (1 - gain)

    skf_pkg::t_state r_state;
    skf_pkg::t_state n_state;

    // configuration
    logic [PERIOD_W-1:0]          r_period;
    logic [VAR_W-1:0]             r_qnoise;
    logic [VAR_W-1:0]             r_rnoise;

    // filter state
    logic signed [ANGLE_W-1:0]    r_angle;
    logic [VAR_W-1:0]             r_var;

    // per-item working registers
    logic signed [ANGLE_W-1:0]    r_meas;
    logic [VAR_W-1:0]             r_p;
    logic                         r_den_zero;
    logic signed [ANGLE_W-1:0]    r_pred;
    logic [GAIN_W-1:0]            r_gain;

    // output register
    logic                         r_out_valid;
    logic signed [ANGLE_W-1:0]    r_out_angle;
    logic [GAIN_W-1:0]            r_out_gain;
    logic [VAR_W-1:0]             r_out_var;

    // strobes and datapath
    logic                         in_beat;
    logic                         cfg_beat;
    logic                         out_free;
    logic                         start_delta;
    logic                         start_div;
    logic                         start_corr;
    logic                         finish;

    logic [VAR_W:0]               p_sum;
    logic [VAR_W-1:0]             p_sat;
    logic [DEN_W-1:0]             den;
    logic signed [ERR_W-1:0]      err;
    logic [GAIN_W-1:0]            one_minus_gain;

    logic                         delta_busy;
    logic signed [DP_W-1:0]       delta_prod;
    logic                         div_busy;
    logic [GAIN_W-1:0]            div_quot;
    logic                         corr_busy;
    logic signed [EP_W-1:0]       corr_prod;
    logic                         vmul_busy;
    logic signed [EP_W-1:0]       vmul_prod;

    logic signed [SUM_W-1:0]      pred_sum;
    logic signed [SUM_W-1:0]      angle_sum;
    logic [VAR_W:0]               var_round;
    logic signed [ANGLE_W-1:0]    angle_new;
    logic [VAR_W-1:0]             var_new;

    assign in_beat  = i_in_valid && o_in_ready;
    assign cfg_beat = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Predicted variance, saturated
    always_comb begin
        p_sum = {1'b0, r_var} + {1'b0, r_qnoise};
        p_sat = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
        den   = {1'b0, r_p} + {1'b0, r_rnoise};
    end

    // Prediction: angle + round(rate * period / 2^16), rounding as carry-in
    always_comb begin
        pred_sum = SUM_W'(r_angle) + SUM_W'($signed(delta_prod[DP_W-1:16]))
                   + SUM_W'({1'b0, delta_prod[15]});
    end

    // Innovation and complement of the gain
    always_comb begin
        err = ERR_W'(r_meas) - ERR_W'(r_pred);
        one_minus_gain = skf_pkg::ONE_Q16 - r_gain;
    end

    // Correction and variance update, rounding as carry-in
    always_comb begin
        angle_sum = SUM_W'(r_pred) + SUM_W'($signed(corr_prod[EP_W-1:16]))
                    + SUM_W'({1'b0, corr_prod[15]});
        angle_new = skf_pkg::sat_s32(angle_sum);
        var_round = {1'b0, vmul_prod[VAR_W+15:16]} + (VAR_W+1)'(vmul_prod[15]);
        var_new   = var_round[VAR_W-1:0];
    end

    // rate * period
    skf_serial_mul #(
        .A_W (ANGLE_W),
        .B_W (PERIOD_W)
    ) u_delta_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_delta),
        .i_a     (i_angular_rate),
        .i_b     (r_period),
        .o_busy  (delta_busy),
        .o_prod  (delta_prod)
    );

    // gain = P * 2^16 / (P + R)
    skf_serial_div #(
        .NUM_W (VAR_W),
        .DEN_W (DEN_W),
        .Q_W   (GAIN_W)
    ) u_gain_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_div),
        .i_num   (r_p),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // innovation * gain
    skf_serial_mul #(
        .A_W (ERR_W),
        .B_W (GAIN_W)
    ) u_corr_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_corr),
        .i_a     (err),
        .i_b     (r_gain),
        .o_busy  (corr_busy),
        .o_prod  (corr_prod)
    );

    // P * (1 - gain)
    skf_serial_mul #(
        .A_W (ERR_W),
        .B_W (GAIN_W)
    ) u_var_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_corr),
        .i_a     ({1'b0, r_p}),
        .i_b     (one_minus_gain),
        .o_busy  (vmul_busy),
        .o_prod  (vmul_prod)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        start_delta = 1'b0;
        start_div   = 1'b0;
        start_corr  = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            skf_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                start_delta = i_in_valid;
                if (i_in_valid) begin
                    n_state = skf_pkg::S_DIV_START;
                end
            end
            skf_pkg::S_DIV_START: begin
                start_div = 1'b1;
                n_state   = skf_pkg::S_PHASE1;
            end
            skf_pkg::S_PHASE1: begin
                if (!div_busy && !delta_busy) begin
                    n_state = skf_pkg::S_PRED;
                end
            end
            skf_pkg::S_PRED: begin
                n_state = skf_pkg::S_ERR;
            end
            skf_pkg::S_ERR: begin
                start_corr = 1'b1;
                n_state    = skf_pkg::S_PHASE2;
            end
            skf_pkg::S_PHASE2: begin
                if (!corr_busy && !vmul_busy) begin
                    n_state = skf_pkg::S_FINISH;
                end
            end
            skf_pkg::S_FINISH: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = skf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skf_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration registers and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= skf_pkg::PERIOD_RST;
            r_qnoise <= skf_pkg::QNOISE_RST;
            r_rnoise <= skf_pkg::RNOISE_RST;
            r_var    <= skf_pkg::VAR_RST;
            r_angle  <= '0;
        end else begin
            if (cfg_beat) begin
                unique case (i_cfg_index)
                    skf_pkg::CFG_SAMPLE_PERIOD: begin
                        r_period <= i_cfg_data[PERIOD_W-1:0];
                    end
                    skf_pkg::CFG_PROCESS_NOISE: begin
                        r_qnoise <= i_cfg_data[VAR_W-1:0];
                    end
                    skf_pkg::CFG_MEASUREMENT_NOISE: begin
                        r_rnoise <= i_cfg_data[VAR_W-1:0];
                    end
                    skf_pkg::CFG_INITIAL_VARIANCE: begin
                        r_var <= i_cfg_data[VAR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (finish) begin
                r_angle <= angle_new;
                r_var   <= var_new;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_meas <= i_measured_angle;
            r_p    <= p_sat;
        end
        if (start_div) begin
            r_den_zero <= (den == '0);
        end
        if (r_state == skf_pkg::S_PRED) begin
            r_pred <= skf_pkg::sat_s32(pred_sum);
            r_gain <= r_den_zero ? '0 : div_quot;
        end
    end

    // Output register: load on finish, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_angle <= angle_new;
            r_out_gain  <= r_gain;
            r_out_var   <= var_new;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_out_angle;
    assign o_gain_used      = r_out_gain;
    assign o_variance_now   = r_out_var;
    assign o_cfg_ready      = 1'b1;

endmodule

>>> hdl/skf_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
// One multiplier bit per cycle, LSB first. Depends on nothing outside itself.
module skf_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [A_W-1:0]    i_a,
    input  logic [B_W-1:0]           i_b,
    output logic                     o_busy,
    output logic signed [A_W+B_W-1:0] o_prod
);

    localparam int P_W = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0]        r_cnt;
    logic signed [P_W-1:0]   r_a_sh;
    logic [B_W-1:0]          r_b_sh;
    logic signed [P_W-1:0]   r_acc;
    logic signed [P_W-1:0]   n_acc;

    // Add the shifted multiplicand when the current multiplier bit is set
    always_comb begin
        n_acc = r_b_sh[0] ? (r_acc + r_a_sh) : r_acc;
    end

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(B_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Load operands, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a_sh <= {{B_W{i_a[A_W-1]}}, i_a};
            r_b_sh <= i_b;
            r_acc  <= '0;
        end else if (r_cnt != '0) begin
            r_a_sh <= r_a_sh <<< 1;
            r_b_sh <= r_b_sh >> 1;
            r_acc  <= n_acc;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_prod = r_acc;

endmodule

>>> hdl/skf_serial_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Gives floor(num * 2^(Q_W-1) / den) for num <= den. No dependencies.
module skf_serial_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 33,
    parameter int Q_W   = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_busy,
    output logic [Q_W-1:0]    o_quot
);

    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_quot;
    logic              ge;
    logic [REM_W-1:0]  diff;
    logic [REM_W-1:0]  n_rem;

    // Trial subtract against the divisor
    always_comb begin
        ge    = (r_rem >= {1'b0, r_den});
        diff  = r_rem - {1'b0, r_den};
        n_rem = ge ? diff : r_rem;
    end

    // Count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Load the dividend, then shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= REM_W'(i_num);
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= {n_rem[REM_W-2:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

>>> hdl/skf_checker.sv
// Port-level checks for the scalar angle Kalman filter, bound to the top level.
// Depends on skf_pkg and scalar_angle_kalman_filter.
module skf_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   o_in_ready,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [skf_pkg::ANGLE_W-1:0]     o_angle_estimate,
    input  logic [skf_pkg::GAIN_W-1:0]             o_gain_used,
    input  logic [skf_pkg::VAR_W-1:0]              o_variance_now
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_angle_estimate)
            && $stable(o_gain_used) && $stable(o_variance_now))
        else $error("result beat changed while stalled");

    // One item in work: no input beat right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // A result comes out of the last step, never from the idle state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised without a finished item");

    // Gain never exceeds one
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gain_used <= skf_pkg::ONE_Q16))
        else $error("gain above one");

endmodule

bind scalar_angle_kalman_filter skf_checker u_skf_checker (.*);

>>> tb/sv/scalar_angle_kalman_filter_test.sv
`timescale 1ns / 100ps
// Self-checking bench for scalar_angle_kalman_filter: feeds IMU sample beats and register
// writes, predicts the filtered angle, gain and variance of every sample, checks each result.
// Depends on skf_pkg and the filter RTL.
module scalar_angle_kalman_filter_test;

    localparam int ANGLE_W    = skf_pkg::ANGLE_W;
    localparam int VAR_W      = skf_pkg::VAR_W;
    localparam int PERIOD_W   = skf_pkg::PERIOD_W;
    localparam int GAIN_W     = skf_pkg::GAIN_W;
    localparam int CFG_IDX_W  = skf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = skf_pkg::CFG_DATA_W;

    localparam int SETTLE_CYCLES = 4;      // quiet cycles before a register write
    localparam int TAIL_CYCLES   = 120;    // watch for stray beats after the last result
    localparam int HOLD_AT_BEAT  = 500;    // sample count that starts the long receiver hold
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 16;
    localparam int PHASE_SAMPLES = 114;
    localparam int MAX_PRINTS    = 100;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 32'sh8000_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = skf_pkg::CFG_INITIAL_VARIANCE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = '1;

    typedef enum logic [1:0] {FEED_SAMPLE, FEED_WRITE, FEED_DRAIN} t_feed_kind;

    typedef struct {
        t_feed_kind                kind;
        logic signed [ANGLE_W-1:0] angle;
        logic signed [ANGLE_W-1:0] rate;
        logic [CFG_IDX_W-1:0]      index;
        logic [CFG_DATA_W-1:0]     data;
        int unsigned               gap;
    } t_feed_entry;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [GAIN_W-1:0]         gain;
        logic [VAR_W-1:0]          variance;
    } t_estimate;

    // Block ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [ANGLE_W-1:0] i_measured_angle = '0;
    logic signed [ANGLE_W-1:0] i_angular_rate = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [ANGLE_W-1:0] o_angle_estimate;
    logic [GAIN_W-1:0]         o_gain_used;
    logic [VAR_W-1:0]          o_variance_now;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    // Stimulus and scoreboard
    t_feed_entry sensor_feed[$];
    t_estimate   expected_estimates[$];
    int unsigned in_beats = 0;
    int unsigned out_beats = 0;
    int unsigned mismatches = 0;
    logic        calm_feed = 1'b0;
    logic        rx_hold = 1'b0;

    // Filter state and registers as the bench sees them
    logic [PERIOD_W-1:0]       cfg_period;
    logic [VAR_W-1:0]          cfg_qnoise;
    logic [VAR_W-1:0]          cfg_rnoise;
    logic signed [ANGLE_W-1:0] est_angle;
    logic [VAR_W-1:0]          est_variance;

    // Driver and receiver private counters
    int unsigned idle_left;
    int unsigned quiet_cycles;
    int unsigned stall_left;
    int unsigned calm_left;
    logic        rx_calm;
    int unsigned hold_left;
    logic        hold_armed;

    scalar_angle_kalman_filter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured_angle (i_measured_angle),
        .i_angular_rate   (i_angular_rate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_angle_estimate (o_angle_estimate),
        .o_gain_used      (o_gain_used),
        .o_variance_now   (o_variance_now),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Round a Q16 product back to Q0, half way rounds up
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
        if (v > 64'sd2147483647) return ANGLE_MAX;
        if (v < -64'sd2147483648) return ANGLE_MIN;
        return ANGLE_W'(v);
    endfunction

    task automatic reset_model();
        cfg_period   = skf_pkg::PERIOD_RST;
        cfg_qnoise   = skf_pkg::QNOISE_RST;
        cfg_rnoise   = skf_pkg::RNOISE_RST;
        est_angle    = '0;
        est_variance = skf_pkg::VAR_RST;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            skf_pkg::CFG_SAMPLE_PERIOD:     cfg_period = data[PERIOD_W-1:0];
            skf_pkg::CFG_PROCESS_NOISE:     cfg_qnoise = data;
            skf_pkg::CFG_MEASUREMENT_NOISE: cfg_rnoise = data;
            skf_pkg::CFG_INITIAL_VARIANCE:  est_variance = data;
            default: ;
        endcase
    endtask

    // Predict, correct toward the measurement, shrink the variance; queue the result
    task automatic kalman_update(input logic signed [ANGLE_W-1:0] meas,
                                 input logic signed [ANGLE_W-1:0] rate);
        longint          delta;
        longint          pred;
        longint          corr;
        longint unsigned p;
        longint unsigned den;
        longint unsigned g;
        t_estimate       res;
        delta = round_q16(longint'(rate) * longint'(cfg_period));
        pred  = longint'(clamp_angle(longint'(est_angle) + delta));
        p = {32'd0, est_variance} + {32'd0, cfg_qnoise};
        if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
        den = p + {32'd0, cfg_rnoise};
        g = (den == 0) ? 64'd0 : (p << 16) / den;
        corr = round_q16((longint'(meas) - pred) * longint'(g));
        est_angle    = clamp_angle(pred + corr);
        est_variance = VAR_W'((p * (64'd65536 - g) + 64'd32768) >> 16);
        res.angle    = est_angle;
        res.gain     = GAIN_W'(g);
        res.variance = est_variance;
        expected_estimates.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Sender gaps: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_feed) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 40);
        return $urandom_range(41, 150);
    endfunction

    // Receiver stalls: same shape, longer tail
    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 5);
        if (r < 97) return $urandom_range(6, 45);
        return $urandom_range(46, 200);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_q16();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return ANGLE_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        if (sel < 17) return ANGLE_W'($urandom);
        if (sel == 17) return ANGLE_MAX;
        if (sel == 18) return ANGLE_MIN;
        return ANGLE_W'(int'($urandom_range(0, 2)) - 1);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_noise();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel < 6) return $urandom_range(1, 1 << 20);
        if (sel < 9) return $urandom_range(1 << 20, 1 << 28);
        return $urandom;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_period();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return 32'hFFFF;
        if (sel < 7) return $urandom_range(10, 2000);
        return $urandom;
    endfunction

    task automatic add_sample(input logic signed [ANGLE_W-1:0] angle,
                              input logic signed [ANGLE_W-1:0] rate);
        t_feed_entry e;
        e.kind = FEED_SAMPLE;
        e.angle = angle;
        e.rate = rate;
        e.index = '0;
        e.data = '0;
        e.gap = pick_gap();
        sensor_feed.push_back(e);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_feed_entry e;
        e.kind = FEED_WRITE;
        e.angle = '0;
        e.rate = '0;
        e.index = idx;
        e.data = data;
        e.gap = pick_gap();
        sensor_feed.push_back(e);
    endtask

    task automatic add_drain();
        t_feed_entry e;
        e.kind = FEED_DRAIN;
        e.angle = '0;
        e.rate = '0;
        e.index = '0;
        e.data = '0;
        e.gap = 0;
        sensor_feed.push_back(e);
    endtask

    // Driver: retire taken beats, then offer the next entry of the feed
    always @(posedge i_clk) begin
        logic        offer_in;
        logic        offer_cfg;
        logic        took;
        int unsigned owed;
        t_feed_entry head;
        if (!i_rst_n) begin
            reset_model();
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            in_beats <= 0;
            idle_left = 0;
            quiet_cycles = 0;
        end else begin
            offer_in = i_in_valid;
            offer_cfg = i_cfg_valid;
            took = 1'b0;
            owed = in_beats - out_beats;
            if (i_in_valid && o_in_ready) begin
                kalman_update(i_measured_angle, i_angular_rate);
                in_beats <= in_beats + 1;
                owed++;
                offer_in = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
                offer_cfg = 1'b0;
            end
            quiet_cycles = (owed == 0) ? quiet_cycles + 1 : 0;
            if (!offer_in && !offer_cfg && sensor_feed.size() != 0) begin
                if (idle_left != 0) begin
                    idle_left--;
                end else begin
                    head = sensor_feed[0];
                    case (head.kind)
                        FEED_SAMPLE: begin
                            i_measured_angle <= head.angle;
                            i_angular_rate <= head.rate;
                            offer_in = 1'b1;
                            took = 1'b1;
                        end
                        // write only once the filter has gone idle
                        FEED_WRITE: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                i_cfg_index <= head.index;
                                i_cfg_data <= head.data;
                                offer_cfg = 1'b1;
                                took = 1'b1;
                            end
                        end
                        FEED_DRAIN: took = (quiet_cycles >= SETTLE_CYCLES);
                        default: took = 1'b1;
                    endcase
                    if (took) begin
                        head = sensor_feed.pop_front();
                        idle_left = (sensor_feed.size() != 0) ? sensor_feed[0].gap : 0;
                    end
                end
            end
            i_in_valid <= offer_in;
            i_cfg_valid <= offer_cfg;
        end
    end

    // Long receiver hold-off so the filter backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 1'b0;
            hold_left = 0;
            hold_armed = 1'b1;
        end else if (hold_armed && in_beats >= HOLD_AT_BEAT) begin
            rx_hold <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_armed = 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            if (hold_left == 0) rx_hold <= 1'b0;
        end
    end

    // Monitor: check each result beat against the oldest prediction, drive ready
    always @(posedge i_clk) begin
        t_estimate want;
        logic      ready_next;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_beats <= 0;
            stall_left = 0;
            calm_left = 0;
            rx_calm = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                out_beats <= out_beats + 1;
                if (expected_estimates.size() == 0) begin
                    report_mismatch("result beat with no sample outstanding",
                                    o_angle_estimate, '0);
                end else begin
                    want = expected_estimates.pop_front();
                    if (o_angle_estimate !== want.angle)
                        report_mismatch("angle_estimate", o_angle_estimate, want.angle);
                    if (o_gain_used !== want.gain)
                        report_mismatch("gain_used", 32'(o_gain_used), 32'(want.gain));
                    if (o_variance_now !== want.variance)
                        report_mismatch("variance_now", o_variance_now, want.variance);
                end
                stall_left = rx_calm ? 0 : pick_stall();
            end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 15) == 0) begin
                stall_left = pick_stall();
            end
            // alternate calm and jittery stretches
            if (calm_left == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(200, 800);
            end else begin
                calm_left--;
            end
            ready_next = (stall_left == 0);
            if (stall_left != 0) stall_left--;
            i_out_ready <= ready_next && !rx_hold;
        end
    end

    // Stimulus: fill the feed, release reset, wait for the last result
    initial begin
        // rails of both fields at the reset settings
        add_sample(0, 0);
        add_sample(ANGLE_MAX, 0);
        add_sample(ANGLE_MIN, 0);
        add_sample(0, ANGLE_MAX);
        add_sample(0, ANGLE_MIN);
        add_sample(ANGLE_MAX, ANGLE_MAX);
        add_sample(ANGLE_MIN, ANGLE_MIN);
        add_sample(-1, 1);
        add_sample(1, -1);
        // longest period drives the predicted angle into both rails
        add_write(skf_pkg::CFG_SAMPLE_PERIOD, 32'hFFFF);
        repeat (3) add_sample(ANGLE_MAX, ANGLE_MAX);
        repeat (2) add_sample(ANGLE_MIN, ANGLE_MIN);
        add_write(skf_pkg::CFG_SAMPLE_PERIOD, '0);
        add_sample(32'sd12345, ANGLE_MAX);
        // no measurement noise: full gain, angle snaps to the measurement
        add_write(skf_pkg::CFG_MEASUREMENT_NOISE, '0);
        add_sample(32'sd70000, 0);
        // variance and both noises now zero: gain falls back to zero
        add_sample(ANGLE_MAX, -5);
        add_sample(ANGLE_MIN, 5);
        // saturate the predicted variance
        add_write(skf_pkg::CFG_INITIAL_VARIANCE, '1);
        add_write(skf_pkg::CFG_PROCESS_NOISE, '1);
        add_write(skf_pkg::CFG_MEASUREMENT_NOISE, '1);
        add_sample(ANGLE_MAX, 0);
        add_sample(ANGLE_MIN, 32'sd1000);
        // writes past the last register change nothing
        add_write(CFG_FIRST_UNUSED, $urandom);
        add_write(CFG_LAST_INDEX, $urandom);
        add_sample(-32'sd65536, 32'sd65536);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm_feed = ($urandom_range(0, 3) == 0);
            if (ph == NUM_PHASES - 1) begin
                add_write(skf_pkg::CFG_SAMPLE_PERIOD, 32'(skf_pkg::PERIOD_RST));
                add_write(skf_pkg::CFG_PROCESS_NOISE, skf_pkg::QNOISE_RST);
                add_write(skf_pkg::CFG_MEASUREMENT_NOISE, skf_pkg::RNOISE_RST);
                add_write(skf_pkg::CFG_INITIAL_VARIANCE, skf_pkg::VAR_RST);
            end else begin
                add_write(skf_pkg::CFG_SAMPLE_PERIOD, pick_period());
                add_write(skf_pkg::CFG_PROCESS_NOISE, pick_noise());
                add_write(skf_pkg::CFG_MEASUREMENT_NOISE, pick_noise());
                if (ph == 0)
                    add_write(skf_pkg::CFG_INITIAL_VARIANCE, '0);
                else if ($urandom_range(0, 1) == 0)
                    add_write(skf_pkg::CFG_INITIAL_VARIANCE, pick_noise());
                if ($urandom_range(0, 7) == 0)
                    add_write(CFG_IDX_W'($urandom_range(int'(CFG_FIRST_UNUSED),
                                                        int'(CFG_LAST_INDEX))), $urandom);
            end
            for (int k = 0; k < PHASE_SAMPLES; k++) begin
                add_sample(pick_q16(), pick_q16());
                if ($urandom_range(0, 59) == 0) add_drain();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (sensor_feed.size() != 0 || i_in_valid || i_cfg_valid || in_beats != out_beats);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_estimates.size() != 0)
            report_mismatch("samples left without a result", expected_estimates.size(), '0);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
